// ===== rtl/klv_pkg.sv =====
`timescale 1ns / 1ps

package klv_pkg;

  localparam int unsigned SIZE_BITS   = 16;
  localparam int unsigned MIN_PACKET  = 16;
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned PREFIX_LEN  = 4;

  typedef logic [7:0] key_prefix_t [PREFIX_LEN];
  localparam key_prefix_t KEY_PREFIX = '{8'h06, 8'h0E, 8'h2B, 8'h34};

  typedef enum logic [2:0] {
    PH_WAIT,
    PH_KEY,
    PH_BER,
    PH_BER_LONG,
    PH_TAG,
    PH_LEN,
    PH_VALUE
  } phase_e;

  typedef enum logic [1:0] {
    ST_VALUE     = 2'd0,
    ST_TOO_SMALL = 2'd1,
    ST_BAD_KEY   = 2'd2,
    ST_BAD_BER   = 2'd3
  } status_e;

  typedef struct packed {
    logic [7:0]           data_byte;
    logic [SIZE_BITS-1:0] packet_size;
    logic                 first_of_packet;
  } in_t;

  typedef struct packed {
    logic [1:0]  status;
    logic [7:0]  tag;
    logic [7:0]  value_length;
    logic [7:0]  value_byte;
    logic [7:0]  byte_offset;
    logic [63:0] value_raw;
    logic        last_of_value;
    logic        empty_value;
  } out_t;

  typedef struct packed {
    status_e    status;
    logic [7:0] tag;
    logic [7:0] value_length;
    logic [7:0] value_byte;
    logic [7:0] byte_offset;
    logic       last;
    logic       empty;
  } cmd_t;

endpackage

// ===== rtl/klv_local_set_parser.sv =====
`timescale 1ns / 1ps

// KLV local set parser. Takes one packet byte per request and emits at most one
// result per byte: one per value byte of each tag-length-value triplet, one for an
// empty value, and one error result (packet too small, bad key, bad BER length)
// after which the rest of the packet is dropped. A new packet starts whenever
// first_of_packet is set. The front parser handles one byte every cycle while the
// queue is not full; results pass through a two-entry queue to an output register
// that builds the running 64-bit big-endian value; sustained rate is one byte per
// cycle while out_ready_i holds. A result goes from queue entry to output register.
module klv_local_set_parser #(
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  klv_pkg::in_t  in_i,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output klv_pkg::out_t out_o
);

  logic          q_full;
  logic          q_push;
  klv_pkg::cmd_t q_push_cmd;
  logic          q_pop;
  logic          q_valid;
  klv_pkg::cmd_t q_pop_cmd;

  klv_front #(
    .KEY_BYTES(KEY_BYTES)
  ) u_front (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_valid_i),
    .in_ready_o(in_ready_o),
    .in_i      (in_i),
    .q_full_i  (q_full),
    .q_push_o  (q_push),
    .q_cmd_o   (q_push_cmd)
  );

  klv_queue u_queue (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (q_push),
    .push_cmd_i(q_push_cmd),
    .full_o    (q_full),
    .pop_i     (q_pop),
    .valid_o   (q_valid),
    .pop_cmd_o (q_pop_cmd)
  );

  klv_back u_back (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .q_valid_i  (q_valid),
    .q_cmd_i    (q_pop_cmd),
    .q_pop_o    (q_pop),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

endmodule

// ===== rtl/klv_front.sv =====
`timescale 1ns / 1ps

module klv_front #(
  parameter int unsigned KEY_BYTES = 16
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_ready_o,
  input  klv_pkg::in_t  in_i,
  input  logic          q_full_i,
  output logic          q_push_o,
  output klv_pkg::cmd_t q_cmd_o
);

  localparam int unsigned SB = klv_pkg::SIZE_BITS;
  localparam logic [SB-1:0] KeyEnd = SB'(KEY_BYTES);
  localparam logic [SB-1:0] MinPkt = SB'(klv_pkg::MIN_PACKET);
  localparam logic [SB-1:0] PrefixLen = SB'(klv_pkg::PREFIX_LEN);

  klv_pkg::phase_e phase_q, phase_d;
  logic [SB-1:0]   pos_q, pos_d;
  logic [SB-1:0]   size_q, size_d;
  logic [7:0]      tag_q, tag_d;
  logic [7:0]      len_q, len_d;
  logic [7:0]      cnt_q, cnt_d;

  logic            accept;
  logic [7:0]      b;
  logic [SB-1:0]   size_eff;
  logic [SB-1:0]   pos;
  logic [SB-1:0]   pos1;
  logic [SB-1:0]   remaining;
  logic            at_end;
  logic            emit;
  klv_pkg::cmd_t   cmd;
  logic            last;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;
  assign q_push_o   = accept && emit;
  assign q_cmd_o    = cmd;

  always_comb begin
    b         = in_i.data_byte;
    size_eff  = in_i.first_of_packet ? in_i.packet_size : size_q;
    pos       = in_i.first_of_packet ? '0 : pos_q;
    pos1      = pos + SB'(1);
    remaining = size_eff - pos1;
    at_end    = pos1 >= size_eff;
    last      = ({1'b0, cnt_q} + 9'd1) >= {1'b0, len_q};

    phase_d = phase_q;
    pos_d   = pos_q;
    size_d  = size_q;
    tag_d   = tag_q;
    len_d   = len_q;
    cnt_d   = cnt_q;
    emit    = 1'b0;
    cmd     = '0;

    if (in_i.first_of_packet) begin
      size_d  = in_i.packet_size;
      pos_d   = '0;
      tag_d   = '0;
      len_d   = '0;
      cnt_d   = '0;
      phase_d = klv_pkg::PH_KEY;
    end

    if (in_i.first_of_packet && (in_i.packet_size < MinPkt)) begin
      emit       = 1'b1;
      cmd.status = klv_pkg::ST_TOO_SMALL;
      phase_d    = klv_pkg::PH_WAIT;
    end else if (in_i.first_of_packet || (phase_q != klv_pkg::PH_WAIT)) begin
      pos_d = pos1;
      unique case (phase_d)
        klv_pkg::PH_KEY: begin
          if ((pos < PrefixLen) && (b != klv_pkg::KEY_PREFIX[pos[1:0]])) begin
            emit       = 1'b1;
            cmd.status = klv_pkg::ST_BAD_KEY;
            phase_d    = klv_pkg::PH_WAIT;
          end else if (pos1 >= KeyEnd) begin
            if (at_end) begin
              emit       = 1'b1;
              cmd.status = klv_pkg::ST_BAD_BER;
              phase_d    = klv_pkg::PH_WAIT;
            end else begin
              phase_d = klv_pkg::PH_BER;
            end
          end
        end
        klv_pkg::PH_BER, klv_pkg::PH_BER_LONG: begin
          if ((phase_d == klv_pkg::PH_BER) && b[7]) begin
            if (at_end) begin
              emit       = 1'b1;
              cmd.status = klv_pkg::ST_BAD_BER;
              phase_d    = klv_pkg::PH_WAIT;
            end else begin
              phase_d = klv_pkg::PH_BER_LONG;
            end
          end else if (SB'(b) > remaining) begin
            emit       = 1'b1;
            cmd.status = klv_pkg::ST_BAD_BER;
            phase_d    = klv_pkg::PH_WAIT;
          end else begin
            phase_d = (remaining == '0) ? klv_pkg::PH_WAIT : klv_pkg::PH_TAG;
          end
        end
        klv_pkg::PH_TAG: begin
          tag_d   = b;
          phase_d = at_end ? klv_pkg::PH_WAIT : klv_pkg::PH_LEN;
        end
        klv_pkg::PH_LEN: begin
          len_d = b;
          if (SB'(b) > remaining) begin
            phase_d = klv_pkg::PH_WAIT;
          end else begin
            cnt_d = '0;
            if (b == 8'd0) begin
              emit             = 1'b1;
              cmd.status       = klv_pkg::ST_VALUE;
              cmd.tag          = tag_q;
              cmd.value_length = b;
              cmd.last         = 1'b1;
              cmd.empty        = 1'b1;
              phase_d          = at_end ? klv_pkg::PH_WAIT : klv_pkg::PH_TAG;
            end else begin
              phase_d = klv_pkg::PH_VALUE;
            end
          end
        end
        klv_pkg::PH_VALUE: begin
          emit             = 1'b1;
          cmd.status       = klv_pkg::ST_VALUE;
          cmd.tag          = tag_q;
          cmd.value_length = len_q;
          cmd.value_byte   = b;
          cmd.byte_offset  = cnt_q;
          cmd.last         = last;
          cnt_d            = cnt_q + 8'd1;
          if (at_end) begin
            phase_d = klv_pkg::PH_WAIT;
          end else if (last) begin
            phase_d = klv_pkg::PH_TAG;
          end
        end
        default: begin
          phase_d = klv_pkg::PH_WAIT;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= klv_pkg::PH_WAIT;
      pos_q   <= '0;
      size_q  <= '0;
      tag_q   <= '0;
      len_q   <= '0;
      cnt_q   <= '0;
    end else if (accept) begin
      phase_q <= phase_d;
      pos_q   <= pos_d;
      size_q  <= size_d;
      tag_q   <= tag_d;
      len_q   <= len_d;
      cnt_q   <= cnt_d;
    end
  end

endmodule

// ===== rtl/klv_queue.sv =====
`timescale 1ns / 1ps

module klv_queue (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          push_i,
  input  klv_pkg::cmd_t push_cmd_i,
  output logic          full_o,
  input  logic          pop_i,
  output logic          valid_o,
  output klv_pkg::cmd_t pop_cmd_o
);

  localparam int unsigned Depth  = klv_pkg::QUEUE_DEPTH;
  localparam int unsigned PtrW   = $clog2(Depth);
  localparam int unsigned CntW   = $clog2(Depth + 1);
  localparam logic [PtrW-1:0] LastIdx = PtrW'(Depth - 1);

  klv_pkg::cmd_t   entry_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [CntW-1:0] cnt_q;

  assign full_o    = cnt_q == CntW'(Depth);
  assign valid_o   = cnt_q != '0;
  assign pop_cmd_o = entry_q[rd_q];

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      entry_q[wr_q] <= push_cmd_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_i) begin
        wr_q <= (wr_q == LastIdx) ? '0 : wr_q + PtrW'(1);
      end
      if (pop_i) begin
        rd_q <= (rd_q == LastIdx) ? '0 : rd_q + PtrW'(1);
      end
      cnt_q <= cnt_q + CntW'(push_i) - CntW'(pop_i);
    end
  end

endmodule

// ===== rtl/klv_back.sv =====
`timescale 1ns / 1ps

module klv_back (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          q_valid_i,
  input  klv_pkg::cmd_t q_cmd_i,
  output logic          q_pop_o,
  output logic          out_valid_o,
  input  logic          out_ready_i,
  output klv_pkg::out_t out_o
);

  logic          out_valid_q, out_valid_d;
  klv_pkg::out_t out_q, out_d;
  logic [63:0]   acc_q, acc_d;
  logic [63:0]   raw;
  logic          is_value;

  assign q_pop_o     = q_valid_i && (!out_valid_q || out_ready_i);
  assign out_valid_o = out_valid_q;
  assign out_o       = out_q;

  always_comb begin
    is_value = (q_cmd_i.status == klv_pkg::ST_VALUE) && !q_cmd_i.empty;
    if (!is_value) begin
      raw = '0;
    end else if (q_cmd_i.byte_offset == 8'd0) begin
      raw = {56'd0, q_cmd_i.value_byte};
    end else begin
      raw = {acc_q[55:0], q_cmd_i.value_byte};
    end

    out_d.status        = q_cmd_i.status;
    out_d.tag           = q_cmd_i.tag;
    out_d.value_length  = q_cmd_i.value_length;
    out_d.value_byte    = q_cmd_i.value_byte;
    out_d.byte_offset   = q_cmd_i.byte_offset;
    out_d.value_raw     = raw;
    out_d.last_of_value = q_cmd_i.last;
    out_d.empty_value   = q_cmd_i.empty;

    acc_d = (q_pop_o && is_value) ? raw : acc_q;

    if (q_pop_o) begin
      out_valid_d = 1'b1;
    end else if (out_ready_i) begin
      out_valid_d = 1'b0;
    end else begin
      out_valid_d = out_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (q_pop_o) begin
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
      acc_q       <= '0;
    end else begin
      out_valid_q <= out_valid_d;
      acc_q       <= acc_d;
    end
  end

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps

module tb_top;

  localparam int KEY_LEN      = 16;
  localparam int RANDOM_BYTES = 400;
  localparam int CYCLE_LIMIT  = 500000;
  localparam int DRAIN_CYCLES = 20;

  logic          clk_i       = 1'b0;
  logic          rst_ni      = 1'b0;
  logic          in_valid_i  = 1'b0;
  logic          in_ready_o;
  klv_pkg::in_t  in_i        = '0;
  logic          out_valid_o;
  logic          out_ready_i = 1'b0;
  klv_pkg::out_t out_o;

  klv_local_set_parser #(.KEY_BYTES(KEY_LEN)) dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_i       (in_i),
    .out_valid_o(out_valid_o),
    .out_ready_i(out_ready_i),
    .out_o      (out_o)
  );

  // parser mirror
  klv_pkg::phase_e p_phase = klv_pkg::PH_WAIT;
  int unsigned     p_pos   = 0;
  int unsigned     p_size  = 0;
  logic [7:0]      p_tag   = '0;
  logic [7:0]      p_len   = '0;
  logic [7:0]      p_count = '0;
  logic [63:0]     p_acc   = '0;

  klv_pkg::out_t pending_results[$];
  klv_pkg::out_t oldest_result;
  logic [7:0]    body[$];
  logic [7:0]    pkt[$];

  int in_max_gap  = 16;
  int out_max_gap = 16;
  int stall_cnt   = 0;
  int fail_count  = 0;
  int bytes_sent  = 0;
  int cycle_count = 0;

  always #6 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  function automatic void push_error(klv_pkg::status_e st);
    klv_pkg::out_t r;
    r = '0;
    r.status = st;
    pending_results.push_back(r);
    p_phase = klv_pkg::PH_WAIT;
  endfunction

  function automatic void push_value(logic [7:0] vb, logic [7:0] off, logic is_last,
                                     logic is_empty);
    klv_pkg::out_t r;
    r.status        = klv_pkg::ST_VALUE;
    r.tag           = p_tag;
    r.value_length  = p_len;
    r.value_byte    = vb;
    r.byte_offset   = off;
    r.value_raw     = p_acc;
    r.last_of_value = is_last;
    r.empty_value   = is_empty;
    pending_results.push_back(r);
  endfunction

  function automatic void check_length(logic [7:0] len, int unsigned pos);
    int unsigned room;
    room = p_size - (pos + 1);
    if (32'(len) > room) push_error(klv_pkg::ST_BAD_BER);
    else p_phase = (room == 0) ? klv_pkg::PH_WAIT : klv_pkg::PH_TAG;
  endfunction

  function automatic void parse_byte(klv_pkg::in_t item);
    logic [7:0]  b;
    int unsigned pos;
    bit          at_end;
    bit          is_last;
    b = item.data_byte;
    if (item.first_of_packet) begin
      p_size  = 32'(item.packet_size);
      p_pos   = 0;
      p_tag   = '0;
      p_len   = '0;
      p_count = '0;
      p_acc   = '0;
      if (p_size < klv_pkg::MIN_PACKET) begin
        push_error(klv_pkg::ST_TOO_SMALL);
        return;
      end
      p_phase = klv_pkg::PH_KEY;
    end
    if (p_phase == klv_pkg::PH_WAIT) return;
    pos    = p_pos;
    p_pos  = pos + 1;
    at_end = (pos + 1 >= p_size);
    case (p_phase)
      klv_pkg::PH_KEY: begin
        if (pos < klv_pkg::PREFIX_LEN && b != klv_pkg::KEY_PREFIX[pos]) begin
          push_error(klv_pkg::ST_BAD_KEY);
        end else if (pos + 1 >= KEY_LEN) begin
          if (at_end) push_error(klv_pkg::ST_BAD_BER);
          else p_phase = klv_pkg::PH_BER;
        end
      end
      klv_pkg::PH_BER: begin
        if (b[7]) begin
          if (at_end) push_error(klv_pkg::ST_BAD_BER);
          else p_phase = klv_pkg::PH_BER_LONG;
        end else begin
          check_length(b, pos);
        end
      end
      klv_pkg::PH_BER_LONG: check_length(b, pos);
      klv_pkg::PH_TAG: begin
        p_tag   = b;
        p_phase = at_end ? klv_pkg::PH_WAIT : klv_pkg::PH_LEN;
      end
      klv_pkg::PH_LEN: begin
        p_len = b;
        if (32'(b) > p_size - (pos + 1)) begin
          p_phase = klv_pkg::PH_WAIT;
        end else begin
          p_count = '0;
          p_acc   = '0;
          if (b == 8'd0) begin
            push_value(8'h00, 8'h00, 1'b1, 1'b1);
            p_phase = at_end ? klv_pkg::PH_WAIT : klv_pkg::PH_TAG;
          end else begin
            p_phase = klv_pkg::PH_VALUE;
          end
        end
      end
      klv_pkg::PH_VALUE: begin
        is_last = (int'(p_count) + 1 >= int'(p_len));
        p_acc   = {p_acc[55:0], b};
        push_value(b, p_count, is_last, 1'b0);
        p_count = p_count + 8'd1;
        if (at_end) p_phase = klv_pkg::PH_WAIT;
        else if (is_last) p_phase = klv_pkg::PH_TAG;
      end
      default: p_phase = klv_pkg::PH_WAIT;
    endcase
  endfunction

  function automatic void cmp_field(string name, logic [63:0] exp_v, logic [63:0] got_v);
    if (got_v !== exp_v) begin
      fail_count++;
      $error("%s: expected %0h, got %0h", name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (pending_results.size() == 0) begin
        fail_count++;
        $error("unexpected result: status %0d tag %0h", out_o.status, out_o.tag);
      end else begin
        oldest_result = pending_results.pop_front();
        cmp_field("status", 64'(oldest_result.status), 64'(out_o.status));
        cmp_field("tag", 64'(oldest_result.tag), 64'(out_o.tag));
        cmp_field("value_length", 64'(oldest_result.value_length),
                  64'(out_o.value_length));
        cmp_field("value_byte", 64'(oldest_result.value_byte), 64'(out_o.value_byte));
        cmp_field("byte_offset", 64'(oldest_result.byte_offset), 64'(out_o.byte_offset));
        cmp_field("value_raw", oldest_result.value_raw, out_o.value_raw);
        cmp_field("last_of_value", 64'(oldest_result.last_of_value),
                  64'(out_o.last_of_value));
        cmp_field("empty_value", 64'(oldest_result.empty_value), 64'(out_o.empty_value));
      end
      stall_cnt = $urandom_range(0, out_max_gap);
    end else if (stall_cnt > 0) begin
      stall_cnt--;
    end
    out_ready_i <= (stall_cnt == 0);
  end

  task automatic send_item(klv_pkg::in_t item);
    int gap;
    gap = $urandom_range(0, in_max_gap);
    if (gap > 0) begin
      in_valid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_i       <= item;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    parse_byte(item);
    bytes_sent++;
  endtask

  // sends n requests from pkt (random filler past its end)
  task automatic send_bytes(int unsigned size, int n, bit starts);
    klv_pkg::in_t item;
    for (int i = 0; i < n; i++) begin
      item.data_byte       = (i < pkt.size()) ? pkt[i] : 8'($urandom);
      item.packet_size     = size[klv_pkg::SIZE_BITS-1:0];
      item.first_of_packet = starts && (i == 0);
      send_item(item);
    end
  endtask

  task automatic add_triplet(logic [7:0] tag, int len);
    body.push_back(tag);
    body.push_back(8'(len));
    repeat (len) body.push_back(8'($urandom));
  endtask

  task automatic build_packet(bit long_form, int unsigned ber_len);
    pkt.delete();
    for (int i = 0; i < KEY_LEN; i++) begin
      if (i < klv_pkg::PREFIX_LEN) pkt.push_back(klv_pkg::KEY_PREFIX[i]);
      else pkt.push_back(8'($urandom));
    end
    if (long_form) pkt.push_back(8'($urandom_range(128, 255)));
    pkt.push_back(ber_len[7:0]);
    foreach (body[i]) pkt.push_back(body[i]);
  endtask

  task automatic test_too_small();
    pkt.delete();
    in_max_gap  = 16;
    out_max_gap = 16;
    send_bytes(40, 2, 1'b0);
    send_bytes(0, 2, 1'b1);
    send_bytes(klv_pkg::MIN_PACKET - 1, 3, 1'b1);
  endtask

  task automatic test_bad_key();
    body.delete();
    for (int p = 0; p < klv_pkg::PREFIX_LEN; p++) begin
      build_packet(1'b0, 0);
      pkt[p] = pkt[p] ^ 8'(1 << $urandom_range(0, 7));
      send_bytes(pkt.size(), p + 1, 1'b1);
    end
  endtask

  task automatic test_ber_limits();
    body.delete();
    build_packet(1'b0, 0);
    send_bytes(KEY_LEN, KEY_LEN, 1'b1);
    build_packet(1'b1, 0);
    send_bytes(KEY_LEN + 1, KEY_LEN + 1, 1'b1);
    build_packet(1'b0, 0);
    send_bytes(KEY_LEN + 1, KEY_LEN + 2, 1'b1);
    add_triplet(8'h01, 2);
    build_packet(1'b0, body.size() + 1);
    send_bytes(pkt.size(), pkt.size(), 1'b1);
    build_packet(1'b1, body.size());
    send_bytes(pkt.size(), pkt.size(), 1'b1);
    // length only checked, walk still covers the body
    build_packet(1'b0, 0);
    send_bytes(pkt.size(), pkt.size(), 1'b1);
  endtask

  task automatic test_triplets();
    body.delete();
    add_triplet(8'h00, 0);
    add_triplet(8'hA5, 9);
    add_triplet(8'hFF, 1);
    body.push_back(8'h7E);
    build_packet(1'b0, body.size());
    send_bytes(pkt.size(), pkt.size(), 1'b1);
    body.delete();
    add_triplet(8'h10, 0);
    body.push_back(8'h22);
    body.push_back(8'h05);
    body.push_back(8'h01);
    build_packet(1'b1, body.size());
    send_bytes(pkt.size(), pkt.size() + 2, 1'b1);
    body.delete();
    add_triplet(8'h5A, 0);
    build_packet(1'b0, body.size());
    send_bytes(pkt.size(), pkt.size(), 1'b1);
  endtask

  task automatic test_long_value();
    body.delete();
    add_triplet(8'hFF, 255);
    build_packet(1'b1, 255);
    in_max_gap  = 0;
    out_max_gap = 16;
    send_bytes(pkt.size(), pkt.size(), 1'b1);
    in_max_gap  = 16;
  endtask

  task automatic test_restart();
    body.delete();
    add_triplet(8'h33, 20);
    build_packet(1'b0, body.size());
    send_bytes(16'hFFFF, 30, 1'b1);
    send_bytes(pkt.size(), 5, 1'b1);
    send_bytes(pkt.size(), pkt.size(), 1'b1);
  endtask

  task automatic test_random_packets();
    int          kind;
    int          pick;
    int          len;
    int          k;
    int          ber;
    int          n;
    int          stop_at;
    int unsigned size;
    bit          long_form;
    stop_at = bytes_sent + RANDOM_BYTES;
    while (bytes_sent < stop_at) begin
      case ($urandom_range(0, 3))
        0: begin in_max_gap = 0;  out_max_gap = 0;  end
        1: begin in_max_gap = 16; out_max_gap = 0;  end
        2: begin in_max_gap = 0;  out_max_gap = 16; end
        default: begin in_max_gap = 16; out_max_gap = 16; end
      endcase
      kind = $urandom_range(0, 99);
      if (kind < 6) begin
        pkt.delete();
        send_bytes($urandom_range(0, klv_pkg::MIN_PACKET - 1), $urandom_range(1, 3), 1'b1);
      end else if (kind < 12) begin
        pkt.delete();
        send_bytes($urandom, $urandom_range(1, 4), 1'b0);
      end else begin
        body.delete();
        repeat ($urandom_range(0, 5)) begin
          pick = $urandom_range(0, 99);
          if (pick < 15) len = 0;
          else if (pick < 75) len = $urandom_range(1, 8);
          else if (pick < 97) len = $urandom_range(9, 20);
          else len = $urandom_range(21, 255);
          add_triplet(8'($urandom), len);
        end
        ber = (body.size() > 255) ? $urandom_range(0, 255) : body.size();
        if ($urandom_range(0, 11) == 0) ber = $urandom_range(0, 255);
        long_form = (ber > 127) ? 1'b1 : 1'($urandom_range(0, 1));
        build_packet(long_form, ber);
        pick = $urandom_range(0, 99);
        if (pick < 8) begin
          pkt[$urandom_range(0, klv_pkg::PREFIX_LEN - 1)] ^= 8'($urandom_range(1, 255));
        end else if (pick < 18) begin
          // cut-off triplet at the tail
          pkt.push_back(8'($urandom));
          if ($urandom_range(0, 1)) begin
            k   = $urandom_range(0, 5);
            len = $urandom_range(k + 1, 255);
            pkt.push_back(8'(len));
            repeat (k) pkt.push_back(8'($urandom));
          end
        end
        size = pkt.size();
        n    = pkt.size();
        if (pick >= 18 && pick < 28) size = $urandom_range(pkt.size(), 65535);
        else if (pick >= 28 && pick < 36) n = $urandom_range(1, pkt.size() - 1);
        else if (pick >= 36 && pick < 44) n = pkt.size() + $urandom_range(1, 4);
        send_bytes(size, n, 1'b1);
      end
    end
  endtask

  initial begin
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    test_too_small();
    test_bad_key();
    test_ber_limits();
    test_triplets();
    test_long_value();
    test_restart();
    test_random_packets();
    in_valid_i <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end

endmodule
